>>> rtl/aot_pkg.sv
// Shared constants, codes and types for the adaptive obstacle threshold block.
`timescale 1ns / 1ps
`default_nettype none
package aot_pkg;

  // Field widths
  localparam int SampleBits = 12;
  localparam int ThrBits    = 13;
  localparam int BiasBits   = 10;
  localparam int MarginBits = 12;
  localparam int SumBits    = 16;
  localparam int CntBits    = 4;
  localparam int StatBits   = 2;
  localparam int TrigBits   = 3;

  // Lanes, one per sensor channel
  localparam int NumLanes   = 3;
  localparam int LaneLeft   = 0;
  localparam int LaneFront  = 1;
  localparam int LaneRight  = 2;

  // Signed width for the near-level compare
  localparam int WideBits = ((SampleBits > ThrBits) ? SampleBits : ThrBits) + 3;

  // Width of the blend numerator avg + 2*base, signed
  localparam int BlendBits = SumBits + 2;
  // Reciprocal of three, exact for numerators below 2^(SumBits+1)
  localparam int RecipShift = SumBits + 1;
  localparam logic [SumBits-1:0] RecipThird = SumBits'(((1 << RecipShift) + 2) / 3);
  localparam int ProdBits = RecipShift + SumBits;

  // Divider: two quotient bits per cycle
  localparam int DivSteps    = SumBits / 2;
  localparam int DivStepBits = $clog2(DivSteps);

  // Policy constants
  localparam logic [ThrBits-1:0]  ThrReset    = ThrBits'(1000);
  localparam logic [SumBits-1:0]  DevLimit    = SumBits'(50);
  localparam logic [CntBits-1:0]  StableLimit = CntBits'(10);
  localparam logic [SumBits-1:0]  BaseFloor   = SumBits'(300);
  localparam logic [TrigBits-1:0] TrigSat     = TrigBits'(7);

  // Stream packing
  localparam int InBits       = 3 * SampleBits + 1;
  localparam int InTdataBits  = ((InBits + 7) / 8) * 8;
  localparam int OutBits      = 2 * StatBits + 2 + 3 * ThrBits;
  localparam int OutTdataBits = ((OutBits + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] RegLeftBias  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegFrontBias = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegRightBias = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegNearMargin = 2'd3;

  // Trigger status codes
  typedef enum logic [StatBits-1:0] {
    StNone  = 2'd0,
    StLeft  = 2'd1,
    StFront = 2'd2,
    StRight = 2'd3
  } status_e;

  // What one lane reports to the merge stage
  typedef struct packed {
    logic trig;
    logic near;
    logic busy;
  } lane_stat_t;

  // Merged classification of one request
  typedef struct packed {
    status_e trig_status;
    status_e limited_status;
    logic    near_flag;
    logic    front_close_flag;
  } merge_res_t;

endpackage
`default_nettype wire

>>> rtl/aot_lane.sv
// One sensor channel: threshold compare, running average and threshold adaptation.
`timescale 1ns / 1ps
`default_nettype none
module aot_lane (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic                            adapt_i,
  input  wire logic [aot_pkg::SampleBits-1:0]  sample_i,
  input  wire logic [aot_pkg::BiasBits-1:0]    bias_i,
  input  wire logic [aot_pkg::MarginBits-1:0]  margin_i,
  output aot_pkg::lane_stat_t                  stat_o,
  output logic [aot_pkg::ThrBits-1:0]          thr_o
);

  typedef enum logic [1:0] {
    LIdle,
    LDiv,
    LEval,
    LUpd
  } lane_state_e;

  lane_state_e state_q, state_d;

  logic [aot_pkg::SumBits-1:0]     sum_q, sum_d;
  logic [aot_pkg::CntBits-1:0]     cnt_q, cnt_d;
  logic [aot_pkg::ThrBits-1:0]     thr_q, thr_d;
  logic [aot_pkg::SumBits-1:0]     dq_q, dq_d;
  logic [aot_pkg::CntBits-1:0]     dv_q, dv_d;
  logic [aot_pkg::CntBits-1:0]     rem_q, rem_d;
  logic [aot_pkg::DivStepBits-1:0] step_q, step_d;
  logic [aot_pkg::SampleBits-1:0]  smp_q, smp_d;
  logic [aot_pkg::ProdBits-1:0]    prod_q, prod_d;
  logic                            neg_q, neg_d;

  logic signed [aot_pkg::WideBits-1:0]  level;
  logic [aot_pkg::SumBits-1:0]          sum_inc;
  logic [aot_pkg::CntBits-1:0]          cnt_inc;
  logic [aot_pkg::SumBits-1:0]          div_q;
  logic [aot_pkg::CntBits-1:0]          div_r;
  logic [aot_pkg::CntBits:0]            part;
  logic signed [aot_pkg::SumBits:0]     diff;
  logic [aot_pkg::SumBits-1:0]          dev;
  logic signed [aot_pkg::BlendBits-1:0] base;
  logic signed [aot_pkg::BlendBits-1:0] numer;
  logic [aot_pkg::SumBits-1:0]          third;
  logic [aot_pkg::SumBits-1:0]          blended;
  logic [aot_pkg::SumBits-1:0]          thr_sum;

  // Compare against the threshold held before this request
  assign level = $signed(aot_pkg::WideBits'(thr_q)) - $signed(aot_pkg::WideBits'(bias_i))
               + $signed(aot_pkg::WideBits'(margin_i));
  assign stat_o.trig = aot_pkg::WideBits'(sample_i) > aot_pkg::WideBits'(thr_q);
  assign stat_o.near = $signed(aot_pkg::WideBits'(sample_i)) > level;
  assign stat_o.busy = (state_q != LIdle);
  assign thr_o       = thr_q;

  assign sum_inc = sum_q + aot_pkg::SumBits'(sample_i);
  assign cnt_inc = cnt_q + aot_pkg::CntBits'(1);

  // Two restoring division steps per cycle
  always_comb begin
    div_q = dq_q;
    div_r = rem_q;
    part  = '0;
    for (int k = 0; k < 2; k++) begin
      part  = {div_r, div_q[aot_pkg::SumBits-1]};
      div_q = {div_q[aot_pkg::SumBits-2:0], 1'b0};
      if (part >= {1'b0, dv_q}) begin
        part     = part - {1'b0, dv_q};
        div_q[0] = 1'b1;
      end
      div_r = part[aot_pkg::CntBits-1:0];
    end
  end

  // Deviation of the average from the sample and the blend numerator
  assign diff  = $signed({1'b0, dq_q}) - $signed((aot_pkg::SumBits + 1)'(smp_q));
  assign dev   = diff[aot_pkg::SumBits] ? aot_pkg::SumBits'(-diff)
                                        : diff[aot_pkg::SumBits-1:0];
  assign base  = $signed(aot_pkg::BlendBits'(thr_q)) - $signed(aot_pkg::BlendBits'(bias_i));
  assign numer = $signed(aot_pkg::BlendBits'(dq_q)) + (base <<< 1);

  // Divide by three, floor at the minimum base, add the bias back
  assign third   = prod_q[aot_pkg::ProdBits-1:aot_pkg::RecipShift];
  assign blended = (neg_q || (third < aot_pkg::BaseFloor)) ? aot_pkg::BaseFloor : third;
  assign thr_sum = blended + aot_pkg::SumBits'(bias_i);

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    thr_d   = thr_q;
    dq_d    = dq_q;
    dv_d    = dv_q;
    rem_d   = rem_q;
    step_d  = step_q;
    smp_d   = smp_q;
    prod_d  = prod_q;
    neg_d   = neg_q;
    case (state_q)
      LIdle: begin
        // Add the sample to the run and start the average
        if (start_i && adapt_i) begin
          sum_d   = sum_inc;
          cnt_d   = cnt_inc;
          dq_d    = sum_inc;
          dv_d    = cnt_inc;
          rem_d   = '0;
          step_d  = '0;
          smp_d   = sample_i;
          state_d = LDiv;
        end
      end
      LDiv: begin
        dq_d   = div_q;
        rem_d  = div_r;
        step_d = step_q + aot_pkg::DivStepBits'(1);
        if (step_q == aot_pkg::DivStepBits'(aot_pkg::DivSteps - 1)) begin
          state_d = LEval;
        end
      end
      LEval: begin
        // Restart the run on a large deviation, blend after a stable run
        prod_d  = aot_pkg::ProdBits'(numer[aot_pkg::RecipShift-1:0]) *
                  aot_pkg::ProdBits'(aot_pkg::RecipThird);
        neg_d   = numer[aot_pkg::BlendBits-1];
        state_d = LIdle;
        if (dev > aot_pkg::DevLimit) begin
          sum_d = '0;
          cnt_d = '0;
        end else if (cnt_q > aot_pkg::StableLimit) begin
          cnt_d   = '0;
          state_d = LUpd;
        end
      end
      LUpd: begin
        thr_d   = thr_sum[aot_pkg::ThrBits-1:0];
        state_d = LIdle;
      end
      default: state_d = LIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LIdle;
      sum_q   <= '0;
      cnt_q   <= '0;
      thr_q   <= aot_pkg::ThrReset;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      thr_q   <= thr_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    dv_q   <= dv_d;
    rem_q  <= rem_d;
    smp_q  <= smp_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
  end

endmodule
`default_nettype wire

>>> rtl/aot_merge.sv
// Merge stage: status priority, near flags and the consecutive-trigger limiter.
`timescale 1ns / 1ps
`default_nettype none
module aot_merge (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire aot_pkg::lane_stat_t lane_i [aot_pkg::NumLanes],
  output aot_pkg::merge_res_t      res_o
);

  aot_pkg::status_e              status;
  logic [aot_pkg::TrigBits-1:0]  trig_cnt_q, trig_cnt_d;
  aot_pkg::merge_res_t           res_q, res_d;

  // Right overrides front, front overrides left
  always_comb begin
    if (lane_i[aot_pkg::LaneRight].trig) begin
      status = aot_pkg::StRight;
    end else if (lane_i[aot_pkg::LaneFront].trig) begin
      status = aot_pkg::StFront;
    end else if (lane_i[aot_pkg::LaneLeft].trig) begin
      status = aot_pkg::StLeft;
    end else begin
      status = aot_pkg::StNone;
    end
  end

  // Count consecutive triggering requests, saturate, clear on a quiet one
  always_comb begin
    trig_cnt_d = trig_cnt_q;
    res_d      = res_q;
    if (accept_i) begin
      if (status == aot_pkg::StNone) begin
        trig_cnt_d = '0;
      end else if (trig_cnt_q < aot_pkg::TrigSat) begin
        trig_cnt_d = trig_cnt_q + aot_pkg::TrigBits'(1);
      end
      res_d.trig_status      = status;
      res_d.limited_status   = (trig_cnt_d >= aot_pkg::TrigSat) ? aot_pkg::StNone : status;
      res_d.front_close_flag = lane_i[aot_pkg::LaneFront].near;
      res_d.near_flag        = lane_i[aot_pkg::LaneLeft].near ||
                               lane_i[aot_pkg::LaneFront].near ||
                               lane_i[aot_pkg::LaneRight].near;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_cnt_q <= '0;
    end else begin
      trig_cnt_q <= trig_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

>>> rtl/adaptive_obstacle_threshold_top.sv
// Top level: stream ports, configuration registers, three channel lanes and the merge stage.
// Without adaptation the result register loads once the request is registered and the
// output is free; with adaptation each lane first runs its two-bit-per-cycle average
// division, then evaluates and, after a stable run, blends its threshold.
// Flow: one request at a time; the next is taken the cycle after the result register loads.
// Reset: asynchronous, active low; thresholds return to 1000, runs, counter and biases to 0.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_obstacle_threshold_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // left_sample, front_sample, right_sample, adapt_enable, zero pad
  input  wire logic [aot_pkg::InTdataBits-1:0]     s_axis_tdata_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // trig_status, limited_status, near_flag, front_close_flag,
  // left_threshold_now, front_threshold_now, right_threshold_now, zero pad
  output logic [aot_pkg::OutTdataBits-1:0]         m_axis_tdata_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [aot_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  wire logic [aot_pkg::MarginBits-1:0]      cfg_wdata_i
);

  logic [aot_pkg::BiasBits-1:0]   bias_q [aot_pkg::NumLanes];
  logic [aot_pkg::MarginBits-1:0] margin_q;

  logic                           busy_q;
  logic                           out_valid_q;
  logic [aot_pkg::OutTdataBits-1:0] out_data_q;

  logic                           accept;
  logic                           adapt_go;
  logic                           lanes_idle;
  logic                           load;
  logic [aot_pkg::SampleBits-1:0] sample [aot_pkg::NumLanes];
  aot_pkg::lane_stat_t            lane_stat [aot_pkg::NumLanes];
  logic [aot_pkg::ThrBits-1:0]    lane_thr [aot_pkg::NumLanes];
  aot_pkg::merge_res_t            merged;

  // Unpack the request
  assign sample[aot_pkg::LaneLeft]  = s_axis_tdata_i[aot_pkg::SampleBits-1:0];
  assign sample[aot_pkg::LaneFront] =
    s_axis_tdata_i[2*aot_pkg::SampleBits-1:aot_pkg::SampleBits];
  assign sample[aot_pkg::LaneRight] =
    s_axis_tdata_i[3*aot_pkg::SampleBits-1:2*aot_pkg::SampleBits];

  assign s_axis_tready_o = !busy_q;
  assign accept          = s_axis_tvalid_i && !busy_q;
  assign adapt_go        = s_axis_tdata_i[3*aot_pkg::SampleBits] &&
                           (sample[aot_pkg::LaneLeft] != '0) &&
                           (sample[aot_pkg::LaneFront] != '0) &&
                           (sample[aot_pkg::LaneRight] != '0);

  for (genvar g = 0; g < aot_pkg::NumLanes; g++) begin : g_lane
    aot_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .start_i  (accept),
      .adapt_i  (adapt_go),
      .sample_i (sample[g]),
      .bias_i   (bias_q[g]),
      .margin_i (margin_q),
      .stat_o   (lane_stat[g]),
      .thr_o    (lane_thr[g])
    );
  end

  aot_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .lane_i   (lane_stat),
    .res_o    (merged)
  );

  assign lanes_idle = !lane_stat[aot_pkg::LaneLeft].busy &&
                      !lane_stat[aot_pkg::LaneFront].busy &&
                      !lane_stat[aot_pkg::LaneRight].busy;
  assign load       = busy_q && lanes_idle && (!out_valid_q || m_axis_tready_i);

  // Hold the request until its result moves to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= aot_pkg::OutTdataBits'({lane_thr[aot_pkg::LaneRight],
                                            lane_thr[aot_pkg::LaneFront],
                                            lane_thr[aot_pkg::LaneLeft],
                                            merged.front_close_flag,
                                            merged.near_flag,
                                            merged.limited_status,
                                            merged.trig_status});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q[aot_pkg::LaneLeft]  <= '0;
      bias_q[aot_pkg::LaneFront] <= '0;
      bias_q[aot_pkg::LaneRight] <= '0;
      margin_q                   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aot_pkg::RegLeftBias:   bias_q[aot_pkg::LaneLeft]  <= cfg_wdata_i[aot_pkg::BiasBits-1:0];
        aot_pkg::RegFrontBias:  bias_q[aot_pkg::LaneFront] <= cfg_wdata_i[aot_pkg::BiasBits-1:0];
        aot_pkg::RegRightBias:  bias_q[aot_pkg::LaneRight] <= cfg_wdata_i[aot_pkg::BiasBits-1:0];
        aot_pkg::RegNearMargin: margin_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
